>>> rtl/fip_pkg.sv
// fip_pkg: shared constants, types and helper functions of the keyed
// index permutation core. No dependencies.
`default_nettype none

package fip_pkg;

  localparam int INDEX_W    = 32;
  localparam int HALF_W     = INDEX_W / 2;
  localparam int HALF_CNT_W = $clog2(HALF_W + 1);
  localparam int BITS_W     = $clog2(INDEX_W + 1);
  localparam int ROUNDS     = 4;
  localparam int RND_W      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int NUM_KEYS   = 4;
  localparam int KEY_SEL_W  = $clog2(NUM_KEYS);
  localparam int KEY_W      = 64;
  localparam int HASH_W     = 64;
  localparam int BYTE_CNT_W = 3;

  // fnv-1a 64 and the avalanche constant
  localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hcbf2_9ce4_8422_2325;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO   = 64'h0000_0000_0000_01b3;
  localparam int                FNV_PRIME_SHFT = 40;
  localparam logic [HASH_W-1:0] MIX_MUL        = 64'hff51_afd7_ed55_8ccd;
  localparam int                MIX_SHIFT      = 33;

  // configuration port
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DOMAIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY0   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY1   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY2   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY3   = 3'd4;

  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] half;
    logic [KEY_W-1:0]  key;
  } fip_rnd_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] f;
  } fip_rnd_rsp_t;

  // low 64 bits of x * 0x100000001b3
  function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
    fnv_mul = (x * FNV_PRIME_LO) + (x << FNV_PRIME_SHFT);
  endfunction

  function automatic logic [7:0] half_byte(input logic [HALF_W-1:0] hv,
                                           input logic [BYTE_CNT_W-1:0] i);
    logic [HASH_W-1:0] w;
    w = HASH_W'(hv) >> {i, 3'b000};
    half_byte = w[7:0];
  endfunction

  // number of significant bits, binary search in a few steps
  function automatic logic [BITS_W-1:0] bit_len(input logic [INDEX_W-1:0] x);
    logic [INDEX_W-1:0] t;
    logic [BITS_W-1:0]  n;
    t = x;
    n = '0;
    if (|t[31:16]) begin
      n = n + BITS_W'(16);
      t = t >> 16;
    end
    if (|t[15:8]) begin
      n = n + BITS_W'(8);
      t = t >> 8;
    end
    if (|t[7:4]) begin
      n = n + BITS_W'(4);
      t = t >> 4;
    end
    if (|t[3:2]) begin
      n = n + BITS_W'(2);
      t = t >> 2;
    end
    if (t[1]) begin
      n = n + BITS_W'(1);
      t = t >> 1;
    end
    bit_len = n + BITS_W'(t[0]);
  endfunction

endpackage

`default_nettype wire

>>> rtl/fip_in_if.sv
// fip_in_if: request channel (mode, index) with valid/ready.
// Depends on fip_pkg.
`default_nettype none

interface fip_in_if import fip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output mode, output index, input ready);
  modport sink   (input valid, input mode, input index, output ready);
endinterface

`default_nettype wire

>>> rtl/fip_out_if.sv
// fip_out_if: result channel (mapped_index, out_of_range) with valid/ready.
// Depends on fip_pkg.
`default_nettype none

interface fip_out_if import fip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] mapped_index;
  logic               out_of_range;

  modport source (output valid, output mapped_index, output out_of_range, input ready);
  modport sink   (input valid, input mapped_index, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> rtl/fip_rnd.sv
// fip_rnd: feistel round function, fnv-1a over 8 bytes, key mix and
// avalanche (its multiply on one 32x32 multiplier) under a small sequencer. Depends on fip_pkg.
`default_nettype none

module fip_rnd import fip_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fip_rnd_req_t req_i,
  output fip_rnd_rsp_t rsp_o
);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_FNV  = 3'd1;
  localparam logic [2:0] R_KEY  = 3'd2;
  localparam logic [2:0] R_SH1  = 3'd3;
  localparam logic [2:0] R_M0   = 3'd4;
  localparam logic [2:0] R_M1   = 3'd5;
  localparam logic [2:0] R_M2   = 3'd6;
  localparam logic [2:0] R_FIN  = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [BYTE_CNT_W-1:0] byte_q, byte_d;
  logic [HALF_W-1:0]     half_q, half_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [HASH_W-1:0]     h_q, h_d;
  logic [HASH_W-1:0]     p_q, p_d;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;

  // shared multiplier: three partial products give the low 64 bits
  always_comb begin
    mul_a = (state_q == R_M1) ? h_q[63:32] : h_q[31:0];
    mul_b = (state_q == R_M2) ? MIX_MUL[63:32] : MIX_MUL[31:0];
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    half_d  = half_q;
    key_d   = key_q;
    h_d     = h_q;
    p_d     = p_q;
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          half_d  = req_i.half;
          key_d   = req_i.key;
          h_d     = fnv_mul(FNV_BASIS ^ HASH_W'(half_byte(req_i.half, '0)));
          byte_d  = BYTE_CNT_W'(1);
          state_d = R_FNV;
        end
      end
      R_FNV: begin
        h_d    = fnv_mul(h_q ^ HASH_W'(half_byte(half_q, byte_q)));
        byte_d = byte_q + BYTE_CNT_W'(1);
        if (byte_q == '1) begin
          state_d = R_KEY;
        end
      end
      R_KEY: begin
        h_d     = fnv_mul(h_q ^ key_q);
        state_d = R_SH1;
      end
      R_SH1: begin
        h_d     = h_q ^ (h_q >> MIX_SHIFT);
        state_d = R_M0;
      end
      R_M0: begin
        p_d     = prod;
        state_d = R_M1;
      end
      R_M1: begin
        p_d     = p_q + {prod[31:0], 32'd0};
        state_d = R_M2;
      end
      R_M2: begin
        p_d     = p_q + {prod[31:0], 32'd0};
        state_d = R_FIN;
      end
      R_FIN: begin
        state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      byte_q  <= '0;
    end else begin
      state_q <= state_d;
      byte_q  <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    half_q <= half_d;
    key_q  <= key_d;
    h_q    <= h_d;
    p_q    <= p_d;
  end

  assign rsp_o.done = (state_q == R_FIN);
  assign rsp_o.f    = p_q ^ (p_q >> MIX_SHIFT);

endmodule

`default_nettype wire

>>> rtl/feistel_index_permutation_core.sv
// feistel_index_permutation_core: keyed permutation of [0, domain_size) by a
// balanced feistel network with cycle walking. Depends on fip_pkg,
// fip_in_if, fip_out_if and fip_rnd.
//
//   channel   dir   payload                        handshake
//   req_i     in    mode, index                    valid/ready
//   rsp_o     out   mapped_index, out_of_range     valid/ready
//   apb       in    domain_size, round_key_0..3    psel/penable/pwrite, pready=1
//
// out of range or a domain of one: result valid in the cycle after accept.
// otherwise each walk pass runs split, 4 rounds, join; each round starts the
// round function and waits for its sequence, whose avalanche uses a 32x32 multiplier.
// passes repeat until the value falls inside the domain, then it is output.
// one item at a time: req_i.ready is low until the result beat is taken.
// reset zeroes the config registers and idles the sequencer, not the datapath.
`default_nettype none

module feistel_index_permutation_core import fip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  fip_in_if.sink            req_i,
  fip_out_if.source         rsp_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPLIT = 3'd1;
  localparam logic [2:0] ST_KICK  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_JOIN  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [INDEX_W-1:0]    domain_q;
  logic [KEY_W-1:0]      key0_q, key1_q, key2_q, key3_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic [2:0]            state_q, state_d;
  logic [RND_W-1:0]      rnd_q, rnd_d;
  logic                  inv_q, inv_d;
  logic [HALF_CNT_W-1:0] half_q, half_d;
  logic [INDEX_W-1:0]    v_q, v_d;
  logic [HALF_W-1:0]     hi_q, hi_d, lo_q, lo_d;
  logic [INDEX_W-1:0]    res_q, res_d;
  logic                  oor_q, oor_d;

  logic [HALF_W-1:0]     mask;
  logic [HALF_W-1:0]     fh;
  logic [INDEX_W-1:0]    joined;
  logic [BITS_W-1:0]     nbits;
  logic [RND_W-1:0]      kidx;
  logic [KEY_SEL_W-1:0]  ksel;
  logic [KEY_W-1:0]      key_sel;
  logic                  in_beat;

  fip_rnd_req_t rnd_req;
  fip_rnd_rsp_t rnd_rsp;

  // configuration port
  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_q <= '0;
      key0_q   <= '0;
      key1_q   <= '0;
      key2_q   <= '0;
      key3_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DOMAIN: domain_q <= pwdata_i[INDEX_W-1:0];
        REG_KEY0:   key0_q   <= pwdata_i;
        REG_KEY1:   key1_q   <= pwdata_i;
        REG_KEY2:   key2_q   <= pwdata_i;
        REG_KEY3:   key3_q   <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DOMAIN: prdata_o = DATA_W'(domain_q);
      REG_KEY0:   prdata_o = key0_q;
      REG_KEY1:   prdata_o = key1_q;
      REG_KEY2:   prdata_o = key2_q;
      REG_KEY3:   prdata_o = key3_q;
      default:    prdata_o = '0;
    endcase
  end

  // round key: inverse runs the schedule backwards
  assign kidx = inv_q ? (RND_W'(ROUNDS - 1) - rnd_q) : rnd_q;
  assign ksel = KEY_SEL_W'(kidx);

  always_comb begin
    unique case (ksel)
      2'd0:    key_sel = key0_q;
      2'd1:    key_sel = key1_q;
      2'd2:    key_sel = key2_q;
      default: key_sel = key3_q;
    endcase
  end

  assign mask    = HALF_W'(((HALF_W + 1)'(1) << half_q) - (HALF_W + 1)'(1));
  assign fh      = rnd_rsp.f[HALF_W-1:0] & mask;
  assign joined  = (INDEX_W'(hi_q) << half_q) | INDEX_W'(lo_q);
  assign nbits   = bit_len(domain_q - INDEX_W'(1));
  assign in_beat = req_i.valid & req_i.ready;

  assign rnd_req.start = (state_q == ST_KICK);
  assign rnd_req.half  = inv_q ? hi_q : lo_q;
  assign rnd_req.key   = key_sel;

  fip_rnd u_rnd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rnd_req),
    .rsp_o  (rnd_rsp)
  );

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    inv_d   = inv_q;
    half_d  = half_q;
    v_d     = v_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    res_d   = res_q;
    oor_d   = oor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          inv_d  = req_i.mode;
          v_d    = req_i.index;
          // halves of ceil(bits / 2), so the width is even
          half_d = HALF_CNT_W'((nbits + BITS_W'(1)) >> 1);
          res_d  = req_i.index;
          if (req_i.index >= domain_q) begin
            oor_d   = 1'b1;
            state_d = ST_OUT;
          end else if (domain_q <= INDEX_W'(1)) begin
            oor_d   = 1'b0;
            state_d = ST_OUT;
          end else begin
            oor_d   = 1'b0;
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        hi_d    = HALF_W'(v_q >> half_q) & mask;
        lo_d    = HALF_W'(v_q) & mask;
        rnd_d   = '0;
        state_d = ST_KICK;
      end
      ST_KICK: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_rsp.done) begin
          if (inv_q) begin
            hi_d = lo_q ^ fh;
            lo_d = hi_q;
          end else begin
            lo_d = hi_q ^ fh;
            hi_d = lo_q;
          end
          if (rnd_q == RND_W'(ROUNDS - 1)) begin
            state_d = ST_JOIN;
          end else begin
            rnd_d   = rnd_q + RND_W'(1);
            state_d = ST_KICK;
          end
        end
      end
      ST_JOIN: begin
        // cycle walk: another pass while outside the domain
        if (joined < domain_q) begin
          res_d   = joined;
          state_d = ST_OUT;
        end else begin
          v_d     = joined;
          state_d = ST_SPLIT;
        end
      end
      ST_OUT: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      inv_q   <= 1'b0;
      half_q  <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      inv_q   <= inv_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    res_q <= res_d;
    oor_q <= oor_d;
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = (state_q == ST_OUT);
  assign rsp_o.mapped_index = res_q;
  assign rsp_o.out_of_range = oor_q;

  // round unit only finishes while the sequencer waits on it
  a_rnd_done_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_rsp.done |-> (state_q == ST_ROUND))
    else $error("round result outside round wait");

  // an in-range result always lands inside the domain
  a_result_in_domain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.out_of_range) |-> (rsp_o.mapped_index < domain_q))
    else $error("mapped index outside domain");

  // an accepted beat leaves idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire
